/* sv/indexed_list_with_free_list_core_defines.svh */
// ----------------------------------------------------------------------------
// Indexed list core assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_WITH_FREE_LIST_CORE_DEFINES_SVH
`define INDEXED_LIST_WITH_FREE_LIST_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ILFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ILFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ILFL_ASSERT(lbl, prop, msg)
`define ILFL_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

/* sv/ilfl_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list package
// Beat types, field widths and command codes for the indexed list core.
// ----------------------------------------------------------------------------
package ilfl_pkg;

  localparam int NODES_DEF = 64;
  localparam int CMD_W     = 2;
  localparam int KEY_W     = 32;
  localparam int IDX_FLD_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [KEY_W-1:0]     key;
    logic [IDX_FLD_W-1:0] node_index;
  } in_beat_t;

  typedef struct packed {
    logic                 ok;
    logic [KEY_W-1:0]     node_key;
    logic                 node_valid;
    logic [IDX_FLD_W-1:0] next_index;
    logic [IDX_FLD_W-1:0] used_head;
    logic [IDX_FLD_W-1:0] free_head;
    logic [IDX_FLD_W-1:0] used_count;
  } out_beat_t;

endpackage

/* sv/indexed_list_with_free_list_core.sv */
// ----------------------------------------------------------------------------
// Indexed list with free list
// Pool of NODES entries threaded into a used list and a FIFO free list.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass (busy high) that writes every
// key to zero and links each entry to the next. A command is taken when start
// is high and busy is low; its result appears for exactly one cycle on
// out_data with out_valid, and cannot be held off. Command timing is set by
// the single read port of the key and link memories: the delete walk reads
// one node per cycle along the used list until the key matches or the list
// ends. A command that fails up front (pool full, list empty, index out of
// range, unknown code) gives its result the next cycle without raising busy.
// ----------------------------------------------------------------------------
`include "indexed_list_with_free_list_core_defines.svh"

module indexed_list_with_free_list_core #(
  parameter int NODES = ilfl_pkg::NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ilfl_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  output ilfl_pkg::out_beat_t  out_data
);

  localparam int AW    = $clog2(NODES);
  localparam int IDX_W = $clog2(NODES + 1);
  localparam int FW    = (IDX_W > ilfl_pkg::IDX_FLD_W) ? IDX_W : ilfl_pkg::IDX_FLD_W;
  localparam logic [IDX_W-1:0] NIL       = IDX_W'(NODES);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(NODES - 1);
  localparam logic [FW-1:0]    NODES_W   = FW'(NODES);

  typedef enum logic [8:0] {
    ST_INIT    = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_ADD_WR1 = 9'b000000100,
    ST_ADD_WR2 = 9'b000001000,
    ST_DEL_CHK = 9'b000010000,
    ST_DEL_W1  = 9'b000100000,
    ST_DEL_W2  = 9'b001000000,
    ST_DEL_W3  = 9'b010000000,
    ST_RD_OUT  = 9'b100000000
  } state_t;

  function automatic logic [ilfl_pkg::IDX_FLD_W-1:0] to_fld(input logic [IDX_W-1:0] v);
    logic [FW-1:0] w;
    w = FW'(v);
    return w[ilfl_pkg::IDX_FLD_W-1:0];
  endfunction

  state_t                    state_r, state_nxt;
  logic [AW-1:0]             init_cnt_r, init_cnt_nxt;
  logic [IDX_W-1:0]          free_first_r, free_first_nxt;
  logic [IDX_W-1:0]          free_last_r, free_last_nxt;
  logic [IDX_W-1:0]          used_first_r, used_first_nxt;
  logic [IDX_W-1:0]          used_last_r, used_last_nxt;
  logic [IDX_W-1:0]          used_total_r, used_total_nxt;
  logic [IDX_W-1:0]          cur_r, cur_nxt;
  logic [IDX_W-1:0]          prior_r, prior_nxt;
  logic [IDX_W-1:0]          link_r, link_nxt;
  logic [IDX_W-1:0]          steps_r, steps_nxt;
  logic [ilfl_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ilfl_pkg::out_beat_t       out_r, out_nxt;

  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      key_we;
  logic [AW-1:0]             key_waddr;
  logic [ilfl_pkg::KEY_W-1:0] key_wdata;
  logic [ilfl_pkg::KEY_W-1:0] key_rdata;
  logic                      link_we;
  logic [AW-1:0]             link_waddr;
  logic [IDX_W-1:0]          link_wdata;
  logic [IDX_W-1:0]          link_rdata;

  logic [FW-1:0]             rd_idx_w;
  logic                      rd_in_range;
  logic [IDX_W-1:0]          free_len;
  logic [IDX_W-1:0]          steps_inc;
  logic                      accept;

  assign accept      = start && !busy;
  assign rd_idx_w    = FW'(in_data.node_index);
  assign rd_in_range = rd_idx_w < NODES_W;
  assign free_len    = NIL - used_total_r;
  assign steps_inc   = steps_r + IDX_W'(1);

  ilfl_ram #(.WIDTH(ilfl_pkg::KEY_W), .DEPTH(NODES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  ilfl_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    free_first_nxt = free_first_r;
    free_last_nxt  = free_last_r;
    used_first_nxt = used_first_r;
    used_last_nxt  = used_last_r;
    used_total_nxt = used_total_r;
    cur_nxt        = cur_r;
    prior_nxt      = prior_r;
    link_nxt       = link_r;
    steps_nxt      = steps_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    key_we         = 1'b0;
    key_waddr      = '0;
    key_wdata      = '0;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;

    // failure/add/delete form; overridden for reads
    out_nxt.ok         = 1'b0;
    out_nxt.node_key   = '0;
    out_nxt.node_valid = 1'b0;
    out_nxt.next_index = to_fld(NIL);

    unique case (state_r)
      ST_INIT: begin
        key_we     = 1'b1;
        key_waddr  = init_cnt_r;
        link_we    = 1'b1;
        link_waddr = init_cnt_r;
        link_wdata = IDX_W'(init_cnt_r) + IDX_W'(1);
        if (init_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          key_nxt = in_data.key;
          unique case (in_data.command)
            ilfl_pkg::CMD_ADD: begin
              if (used_total_r >= NIL || free_first_r >= NIL) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = free_first_r[AW-1:0];
                cur_nxt   = free_first_r;
                state_nxt = ST_ADD_WR1;
              end
            end
            ilfl_pkg::CMD_DEL: begin
              if (used_total_r == '0 || used_first_r >= NIL) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = used_first_r[AW-1:0];
                cur_nxt   = used_first_r;
                prior_nxt = used_first_r;
                steps_nxt = '0;
                state_nxt = ST_DEL_CHK;
              end
            end
            ilfl_pkg::CMD_READ: begin
              if (rd_in_range) begin
                rd_en     = 1'b1;
                rd_addr   = rd_idx_w[AW-1:0];
                state_nxt = ST_RD_OUT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ADD_WR1: begin
        link_nxt   = link_rdata;
        key_we     = 1'b1;
        key_waddr  = cur_r[AW-1:0];
        key_wdata  = key_r;
        link_we    = 1'b1;
        link_waddr = cur_r[AW-1:0];
        link_wdata = NIL;
        state_nxt  = ST_ADD_WR2;
      end
      ST_ADD_WR2: begin
        if (used_total_r != '0 && used_last_r < NIL) begin
          link_we    = 1'b1;
          link_waddr = used_last_r[AW-1:0];
          link_wdata = cur_r;
        end else begin
          used_first_nxt = cur_r;
        end
        if (free_len > IDX_W'(1)) begin
          free_first_nxt = link_r;
        end else begin
          free_first_nxt = NIL;
          free_last_nxt  = NIL;
        end
        used_last_nxt  = cur_r;
        used_total_nxt = used_total_r + IDX_W'(1);
        out_nxt.ok     = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_DEL_CHK: begin
        if (key_rdata == key_r) begin
          link_nxt  = link_rdata;
          state_nxt = ST_DEL_W1;
        end else begin
          steps_nxt = steps_inc;
          prior_nxt = cur_r;
          cur_nxt   = link_rdata;
          if (steps_inc < NIL && link_rdata < NIL) begin
            rd_en   = 1'b1;
            rd_addr = link_rdata[AW-1:0];
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_DEL_W1: begin
        key_we     = 1'b1;
        key_waddr  = cur_r[AW-1:0];
        link_we    = 1'b1;
        link_waddr = cur_r[AW-1:0];
        link_wdata = NIL;
        state_nxt  = ST_DEL_W2;
      end
      ST_DEL_W2: begin
        if (cur_r != used_first_r) begin
          link_we    = 1'b1;
          link_waddr = prior_r[AW-1:0];
          link_wdata = link_r;
        end
        state_nxt = ST_DEL_W3;
      end
      ST_DEL_W3: begin
        if (free_len != '0 && free_last_r < NIL) begin
          link_we    = 1'b1;
          link_waddr = free_last_r[AW-1:0];
          link_wdata = cur_r;
        end else begin
          free_first_nxt = cur_r;
        end
        free_last_nxt  = cur_r;
        used_total_nxt = used_total_r - IDX_W'(1);
        if (cur_r == used_first_r) begin
          used_first_nxt = link_r;
          if (used_total_r == IDX_W'(1)) begin
            used_last_nxt = NIL;
          end
        end else if (link_r >= NIL) begin
          used_last_nxt = prior_r;
        end
        out_nxt.ok    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RD_OUT: begin
        out_nxt.ok         = 1'b1;
        out_nxt.node_key   = key_rdata;
        out_nxt.node_valid = |key_rdata;
        out_nxt.next_index = to_fld(link_rdata);
        out_valid_nxt      = 1'b1;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_nxt.used_head  = to_fld(used_first_nxt);
    out_nxt.free_head  = to_fld(free_first_nxt);
    out_nxt.used_count = to_fld(used_total_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_cnt_r   <= '0;
      free_first_r <= '0;
      free_last_r  <= IDX_W'(NODES - 1);
      used_first_r <= NIL;
      used_last_r  <= NIL;
      used_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      free_first_r <= free_first_nxt;
      free_last_r  <= free_last_nxt;
      used_first_r <= used_first_nxt;
      used_last_r  <= used_last_nxt;
      used_total_r <= used_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prior_r <= prior_nxt;
    link_r  <= link_nxt;
    steps_r <= steps_nxt;
    key_r   <= key_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ILFL_ASSERT(a_count_range, used_total_r <= NIL, "used count above pool size")
  `ILFL_ASSERT_IMP(a_empty_null, used_total_r == '0, used_first_r == NIL && used_last_r == NIL, "empty used list with non-null ends")
  `ILFL_ASSERT_IMP(a_full_null, used_total_r == NIL, free_first_r == NIL, "full pool with non-null free head")
  `ILFL_ASSERT_IMP(a_read_lat, accept && in_data.command == ilfl_pkg::CMD_READ && rd_in_range, ##2 out_valid_r, "read result missing")

endmodule

/* sv/ilfl_ram.sv */
// ----------------------------------------------------------------------------
// Indexed list RAM
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ilfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* tb/indexed_list_with_free_list_core_tb.sv */
// ----------------------------------------------------------------------------
// Indexed list with free list - core testbench
// Drives add, delete and read commands through the start/busy port and keeps
// a shadow pool of keys and links, both lists and the used count. Each
// result beat is compared field by field with the next predicted beat.
// Stimulus is a directed opening followed by random fill, drain and mixed
// phases with random idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import ilfl_pkg::*;

class list_scoreboard;
  localparam logic [IDX_FLD_W-1:0] NULL_IDX = IDX_FLD_W'(NODES_DEF);

  logic [KEY_W-1:0]     key_mem  [NODES_DEF];
  logic [IDX_FLD_W-1:0] link_mem [NODES_DEF];
  logic [IDX_FLD_W-1:0] free_first, free_last, used_first, used_last, used_total;
  out_beat_t            expected_q [$];
  int                   errors;

  function new();
    for (int i = 0; i < NODES_DEF; i++) begin
      key_mem[i]  = '0;
      link_mem[i] = IDX_FLD_W'(i + 1);
    end
    free_first = '0;
    free_last  = IDX_FLD_W'(NODES_DEF - 1);
    used_first = NULL_IDX;
    used_last  = NULL_IDX;
    used_total = '0;
    errors     = 0;
  endfunction

  function bit add_key(logic [KEY_W-1:0] key);
    int                   free_len;
    logic [IDX_FLD_W-1:0] n;
    free_len = NODES_DEF - int'(used_total);
    n = free_first;
    if (free_len == 0 || n >= NULL_IDX) return 1'b0;
    key_mem[n] = key;
    if (free_len > 1) begin
      free_first = link_mem[n];
    end else begin
      free_first = NULL_IDX;
      free_last  = NULL_IDX;
    end
    if (used_total > 0 && used_last < NULL_IDX) link_mem[used_last] = n;
    else used_first = n;
    link_mem[n] = NULL_IDX;
    used_last   = n;
    used_total++;
    return 1'b1;
  endfunction

  function bit delete_key(logic [KEY_W-1:0] key);
    int                   free_len;
    int                   steps;
    bit                   found;
    logic [IDX_FLD_W-1:0] n, prior;
    if (used_total == 0) return 1'b0;
    free_len = NODES_DEF - int'(used_total);
    n     = used_first;
    prior = used_first;
    steps = 0;
    found = 1'b0;
    while (!found && steps < NODES_DEF && n < NULL_IDX) begin
      if (key_mem[n] == key) begin
        found = 1'b1;
      end else begin
        prior = n;
        n     = link_mem[n];
        steps++;
      end
    end
    if (!found) return 1'b0;
    if (n == used_first) begin
      used_first = link_mem[n];
      used_total--;
      if (used_total == 0) used_last = NULL_IDX;
    end else begin
      link_mem[prior] = link_mem[n];
      used_total--;
      if (link_mem[n] >= NULL_IDX) used_last = prior;
    end
    key_mem[n] = '0;
    if (free_len > 0 && free_last < NULL_IDX) link_mem[free_last] = n;
    else free_first = n;
    link_mem[n] = NULL_IDX;
    free_last   = n;
    return 1'b1;
  endfunction

  function void note_input(in_beat_t b);
    out_beat_t e;
    e = '0;
    e.next_index = NULL_IDX;
    case (b.command)
      CMD_ADD: begin
        e.ok = add_key(b.key);
      end
      CMD_DEL: begin
        e.ok = delete_key(b.key);
      end
      CMD_READ: begin
        if (b.node_index < NULL_IDX) begin
          e.ok         = 1'b1;
          e.node_key   = key_mem[b.node_index];
          e.node_valid = (e.node_key != '0);
          e.next_index = link_mem[b.node_index];
        end
      end
      default: ;
    endcase
    e.used_head  = used_first;
    e.free_head  = free_first;
    e.used_count = used_total;
    expected_q.push_back(e);
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task compare_field(string name, logic [KEY_W-1:0] got, logic [KEY_W-1:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %0h exp %0h", name, got, exp));
  endtask

  task check_result(out_beat_t got);
    out_beat_t e;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected: %h", got));
      return;
    end
    e = expected_q.pop_front();
    compare_field("ok",         KEY_W'(got.ok),         KEY_W'(e.ok));
    compare_field("node_key",   got.node_key,           e.node_key);
    compare_field("node_valid", KEY_W'(got.node_valid), KEY_W'(e.node_valid));
    compare_field("next_index", KEY_W'(got.next_index), KEY_W'(e.next_index));
    compare_field("used_head",  KEY_W'(got.used_head),  KEY_W'(e.used_head));
    compare_field("free_head",  KEY_W'(got.free_head),  KEY_W'(e.free_head));
    compare_field("used_count", KEY_W'(got.used_count), KEY_W'(e.used_count));
  endtask
endclass

module indexed_list_with_free_list_core_tb;

  localparam int                 NODES     = NODES_DEF;
  localparam int                 CYCLE_CAP = 1_000_000;
  localparam int                 ITEMS     = 1900;
  localparam logic [CMD_W-1:0]   CMD_BAD   = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;

  list_scoreboard sb;
  int             cycles;
  int             sent;

  indexed_list_with_free_list_core #(
    .NODES(NODES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("indexed_list_with_free_list_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic in_beat_t mk_beat(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                       logic [IDX_FLD_W-1:0] idx);
    in_beat_t b;
    b.command    = cmd;
    b.key        = key;
    b.node_index = idx;
    return b;
  endfunction

  function automatic int idle_cycles(bit enabled);
    int r;
    r = $urandom_range(99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // start stays high across back-to-back beats; send_beat lowers it only for a gap
  task automatic send_beat(in_beat_t b, int gap);
    start   <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(b);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (sb.expected_q.size() != 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random(int add_pct, int del_pct, bit gaps_on);
    int                   r;
    int                   kr;
    logic [CMD_W-1:0]     cmd;
    logic [KEY_W-1:0]     key;
    logic [IDX_FLD_W-1:0] idx;
    r  = $urandom_range(99);
    kr = $urandom_range(99);
    key = $urandom;
    idx = IDX_FLD_W'($urandom_range(0, 127));
    if (r < add_pct) begin
      cmd = CMD_ADD;
      if (kr < 70) key = $urandom_range(1, 12);
      else if (kr < 75) key = '0;
    end else if (r < add_pct + del_pct) begin
      cmd = CMD_DEL;
      // a key held by some entry gives deep walks; small keys hit early
      if (kr < 50) key = sb.key_mem[$urandom_range(0, NODES - 1)];
      else if (kr < 85) key = $urandom_range(0, 12);
    end else if (r < 97) begin
      cmd = CMD_READ;
      if (kr < 85) idx = IDX_FLD_W'($urandom_range(0, NODES - 1));
      else idx = IDX_FLD_W'($urandom_range(NODES, 127));
    end else begin
      cmd = CMD_BAD;
    end
    send_beat(mk_beat(cmd, key, idx), idle_cycles(gaps_on));
  endtask

  initial begin
    int  kind;
    int  len;
    bit  gaps_on;
    sb      = new();
    cycles  = 0;
    sent    = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening: empty pool, extreme keys and indexes, list edge cases
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd0),   0);
    send_beat(mk_beat(CMD_READ, 32'hFFFFFFFF, 7'd63),  1);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd64),  0);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd127), 2);
    send_beat(mk_beat(CMD_DEL,  32'h5,        7'd0),   0);
    send_beat(mk_beat(CMD_ADD,  32'h0,        7'd127), 0);
    send_beat(mk_beat(CMD_ADD,  32'hFFFFFFFF, 7'd0),   1);
    send_beat(mk_beat(CMD_ADD,  32'h1,        7'd0),   0);
    send_beat(mk_beat(CMD_ADD,  32'h2,        7'd0),   0);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd0),   0);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd1),   3);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd3),   0);
    send_beat(mk_beat(CMD_DEL,  32'h0,        7'd0),   0);
    send_beat(mk_beat(CMD_DEL,  32'h2,        7'd0),   0);
    send_beat(mk_beat(CMD_DEL,  32'h7,        7'd0),   1);
    send_beat(mk_beat(CMD_BAD,  32'hFFFFFFFF, 7'd127), 0);
    send_beat(mk_beat(CMD_ADD,  32'h3,        7'd0),   0);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd4),   0);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd0),   0);
    send_beat(mk_beat(CMD_DEL,  32'h1,        7'd0),   0);
    send_beat(mk_beat(CMD_ADD,  32'h80000000, 7'd0),   0);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd2),   0);
    send_beat(mk_beat(CMD_READ, 32'h0,        7'd63),  1);
    drain_results();

    // first random phase fills the pool past full
    repeat (90) send_random(90, 5, 1'b1);

    while (sent < ITEMS) begin
      kind    = $urandom_range(2);
      len     = $urandom_range(20, 100);
      gaps_on = ($urandom_range(3) != 0);
      repeat (len) begin
        case (kind)
          0:       send_random(75, 10, gaps_on);
          1:       send_random(10, 75, gaps_on);
          default: send_random(40, 35, gaps_on);
        endcase
      end
      if ($urandom_range(3) == 0) drain_results();
    end

    drain_results();
    start <= 1'b0;
    repeat (NODES + 8) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("indexed_list_with_free_list_core test passed");
    end else begin
      $display("indexed_list_with_free_list_core test failed");
    end
    $finish;
  end

endmodule
